// ----- rtl/core/wpst_pkg.sv -----
package wpst_pkg;

    localparam int TIME_W    = 32;
    localparam int DATA_W    = 32;
    localparam int RES_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Divider geometry: numerator is |dv| << 16, divisor is |dt|.
    localparam int DEN_W     = TIME_W + 1;
    localparam int NUM_W     = DATA_W + 1 + 16;
    localparam int QUO_W     = DATA_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START  = 3'd0,
        REG_WINDOW_END    = 3'd1,
        REG_KEEP_LAST_TIE = 3'd2,
        REG_REPORT_TIME   = 3'd3,
        REG_USE_SLOPE     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_UNUSABLE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic set_seen;
        logic consider_val;
        logic load_prev;
        logic latch_ops;
        logic div_start;
        logic consider_quot;
        logic load_out;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_window;
        logic use_slope;
        logic seen;
        logic dt_zero;
        logic div_done;
        logic final_flag;
    } dp_status_t;

endpackage

// ----- rtl/core/wpst_div.sv -----
module wpst_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wpst_pkg::NUM_W-1:0]    num_mag,
    input  logic [wpst_pkg::DEN_W-1:0]    den_mag,
    input  logic                          neg,
    output logic                          done,
    output logic signed [wpst_pkg::QUO_W-1:0] quotient
);
    import wpst_pkg::*;

    localparam logic [QUO_W-1:0] Q_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] Q_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic                 sat_reg, sat_next;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    assign rem_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            // quotient overflows 32 bits when num >= den * 2^32
            sat_next  = {{(DEN_W + QUO_W - NUM_W){1'b0}}, num_mag} >= {den_mag, {QUO_W{1'b0}}};
            rem_next  = {{(DEN_W - (NUM_W - QUO_W)){1'b0}}, num_mag[NUM_W-1:QUO_W]};
            quo_next  = num_mag[QUO_W-1:0];
            den_next  = den_mag;
            neg_next  = neg;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
                rem_next = ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
    end

    assign done = busy_reg && (cnt_reg == '0);

    // sign and saturation
    always_comb begin
        if (sat_reg) begin
            quotient = neg_reg ? Q_MIN : Q_MAX;
        end else if (!neg_reg) begin
            quotient = quo_reg[QUO_W-1] ? Q_MAX : quo_reg;
        end else begin
            quotient = (quo_reg > Q_MIN) ? Q_MIN : (~quo_reg + 1'b1);
        end
    end

endmodule

// ----- rtl/core/wpst_dp.sv -----
module wpst_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  wpst_pkg::ctrl_cmd_t              cmd,
    output wpst_pkg::dp_status_t             status,
    input  logic                             cfg_wr_en,
    input  logic [wpst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wpst_pkg::CFG_DAT_W-1:0]   cfg_wr_data,
    input  logic [wpst_pkg::TIME_W-1:0]      s_sample_time,
    input  logic signed [wpst_pkg::DATA_W-1:0] s_sample_value,
    input  logic                             s_final_sample,
    output logic signed [wpst_pkg::RES_W-1:0] m_result_value,
    output logic [1:0]                       m_status
);
    import wpst_pkg::*;

    localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration
    logic [TIME_W-1:0] win_start_reg, win_end_reg;
    logic              keep_last_reg, report_time_reg, use_slope_reg;

    // tracking state
    logic signed [DATA_W-1:0] best_value_reg, best_value_next;
    logic [TIME_W-1:0]        best_time_reg, best_time_next;
    logic                     seen_reg, seen_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] prev_value_reg, prev_value_next;
    logic [TIME_W-1:0]        prev_time_reg, prev_time_next;

    // captured request
    logic [TIME_W-1:0]        smp_time_reg;
    logic signed [DATA_W-1:0] smp_value_reg;
    logic                     smp_final_reg;

    // divider operands
    logic [NUM_W-1:0] num_mag_reg;
    logic [DEN_W-1:0] den_mag_reg;
    logic             neg_reg;
    logic             dt_zero_reg;

    logic signed [RES_W-1:0] out_value_reg;
    logic [1:0]              out_status_reg;

    logic signed [DEN_W-1:0]  dt, dv;
    logic [DEN_W-1:0]         dt_mag, dv_mag;
    logic                     div_done;
    logic signed [QUO_W-1:0]  div_q;
    logic signed [DATA_W-1:0] cand;
    logic                     take;
    status_t                  st_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg   <= '0;
            win_end_reg     <= '1;
            keep_last_reg   <= 1'b0;
            report_time_reg <= 1'b0;
            use_slope_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_START:  win_start_reg   <= cfg_wr_data[TIME_W-1:0];
                REG_WINDOW_END:    win_end_reg     <= cfg_wr_data[TIME_W-1:0];
                REG_KEEP_LAST_TIE: keep_last_reg   <= cfg_wr_data[0];
                REG_REPORT_TIME:   report_time_reg <= cfg_wr_data[0];
                REG_USE_SLOPE:     use_slope_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            smp_time_reg  <= s_sample_time;
            smp_value_reg <= s_sample_value;
            smp_final_reg <= s_final_sample;
        end
    end

    // operand prep
    assign dt     = $signed({1'b0, smp_time_reg}) - $signed({1'b0, prev_time_reg});
    assign dv     = $signed({smp_value_reg[DATA_W-1], smp_value_reg})
                  - $signed({prev_value_reg[DATA_W-1], prev_value_reg});
    assign dt_mag = dt[DEN_W-1] ? DEN_W'(-dt) : DEN_W'(dt);
    assign dv_mag = dv[DEN_W-1] ? DEN_W'(-dv) : DEN_W'(dv);

    always_ff @(posedge aclk) begin
        if (cmd.latch_ops) begin
            num_mag_reg <= {dv_mag, {(NUM_W-DEN_W){1'b0}}};
            den_mag_reg <= dt_mag;
            neg_reg     <= dv[DEN_W-1] ^ dt[DEN_W-1];
            dt_zero_reg <= (dt == '0);
        end
    end

    wpst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num_mag  (num_mag_reg),
        .den_mag  (den_mag_reg),
        .neg      (neg_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // peak compare
    assign cand = cmd.consider_quot ? div_q : smp_value_reg;
    assign take = !found_reg || (cand > best_value_reg)
               || (keep_last_reg && (cand == best_value_reg));

    always_comb begin
        best_value_next = best_value_reg;
        best_time_next  = best_time_reg;
        seen_next       = seen_reg;
        found_next      = found_reg;
        prev_value_next = prev_value_reg;
        prev_time_next  = prev_time_reg;
        if (cmd.set_seen) begin
            seen_next = 1'b1;
        end
        if ((cmd.consider_val || cmd.consider_quot) && take) begin
            best_value_next = cand;
            best_time_next  = smp_time_reg;
            found_next      = 1'b1;
        end
        if (cmd.load_prev) begin
            prev_value_next = smp_value_reg;
            prev_time_next  = smp_time_reg;
        end
        if (cmd.clear) begin
            best_value_next = V_MIN;
            best_time_next  = '0;
            seen_next       = 1'b0;
            found_next      = 1'b0;
            prev_value_next = '0;
            prev_time_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_value_reg <= V_MIN;
            best_time_reg  <= '0;
            seen_reg       <= 1'b0;
            found_reg      <= 1'b0;
            prev_value_reg <= '0;
            prev_time_reg  <= '0;
        end else begin
            best_value_reg <= best_value_next;
            best_time_reg  <= best_time_next;
            seen_reg       <= seen_next;
            found_reg      <= found_next;
            prev_value_reg <= prev_value_next;
            prev_time_reg  <= prev_time_next;
        end
    end

    // result
    always_comb begin
        if (!seen_reg) begin
            st_code = STATUS_EMPTY;
        end else if (!found_reg) begin
            st_code = STATUS_UNUSABLE;
        end else begin
            st_code = STATUS_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= st_code;
            if (st_code != STATUS_FOUND) begin
                out_value_reg <= '0;
            end else if (report_time_reg) begin
                out_value_reg <= $signed({1'b0, best_time_reg});
            end else begin
                out_value_reg <= $signed({best_value_reg[DATA_W-1], best_value_reg});
            end
        end
    end

    assign m_result_value = out_value_reg;
    assign m_status       = out_status_reg;

    assign status.in_window  = (smp_time_reg >= win_start_reg) && (smp_time_reg <= win_end_reg);
    assign status.use_slope  = use_slope_reg;
    assign status.seen       = seen_reg;
    assign status.dt_zero    = dt_zero_reg;
    assign status.div_done   = div_done;
    assign status.final_flag = smp_final_reg;

endmodule

// ----- rtl/core/wpst_ctrl.sv -----
module wpst_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  wpst_pkg::dp_status_t status,
    output wpst_pkg::ctrl_cmd_t  cmd
);
    import wpst_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.in_window && status.use_slope && status.seen) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PREP: begin
                state_next = status.dt_zero ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.final_flag || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EVAL: begin
                if (status.in_window) begin
                    cmd.set_seen = 1'b1;
                    if (!status.use_slope) begin
                        cmd.consider_val = 1'b1;
                    end else if (!status.seen) begin
                        cmd.load_prev = 1'b1;
                    end else begin
                        cmd.latch_ops = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                if (status.dt_zero) begin
                    cmd.load_prev = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.consider_quot = 1'b1;
                    cmd.load_prev     = 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.final_flag && out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/windowed_peak_or_slope_tracker.sv -----
// Windowed peak / slope tracker. Each request carries a sample time, a signed Q16.16
// value and a final flag; only samples with window_start <= time <= window_end count.
// With use_slope clear the block tracks the largest value; with it set it tracks the
// largest ((v - v_prev) << 16) / (t - t_prev) between consecutive in-window samples,
// saturated to signed 32 bits, where a pair with equal times only refreshes the
// previous sample. The request flagged final produces one result (peak value, or its
// time when report_time is set) plus a status: 0 found, 1 window empty, 2 no usable
// value; the value is 0 for any nonzero status. State then clears; registers stay.
// One request at a time: value mode and out-of-window samples pass through accept,
// window test and emit; an in-window slope sample after the first also passes
// through operand prep and the radix-2 restoring divider (32 quotient bits), and
// skips the divider when the time step is zero. A final request waits in the emit
// state until the output register is free. Configuration writes go straight to the
// registers and are meant for idle periods only; indexes above 4 are ignored.
module windowed_peak_or_slope_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wpst_pkg::TIME_W-1:0]        s_sample_time,
    input  logic signed [wpst_pkg::DATA_W-1:0] s_sample_value,
    input  logic                               s_final_sample,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [wpst_pkg::RES_W-1:0]  m_result_value,
    output logic [1:0]                         m_status,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [wpst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpst_pkg::CFG_DAT_W-1:0]     cfg_wr_data
);
    import wpst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencing: accept, window test, operand prep, divide, emit
    wpst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (cmd)
    );

    // registers, tracking state, divider and result register
    wpst_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (dp_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_sample_time  (s_sample_time),
        .s_sample_value (s_sample_value),
        .s_final_sample (s_final_sample),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

endmodule

// ----- rtl/core/wpst_checker.sv -----
module wpst_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [wpst_pkg::RES_W-1:0]  m_result_value,
    input logic [1:0]                         m_status
);
    import wpst_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result changed while stalled");

    // nonzero status always comes with a zero value
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_FOUND) |-> m_result_value == '0)
        else $error("nonzero value with failure status");

    // one request at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind windowed_peak_or_slope_tracker wpst_checker u_wpst_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wpst_pkg::*;

    // Cycles a slope request may still be busy after its handshake, plus emit slack.
    localparam int          DRAIN_CYCLES   = 48;
    // Cycles with no handshake and no register write before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int          CFG_IDX_MAX    = (1 << CFG_IDX_W) - 1;

    typedef struct {
        logic [TIME_W-1:0] win_lo;
        logic [TIME_W-1:0] win_hi;
        bit                keep_last;
        bit                report_time;
        bit                use_slope;
    } tracker_cfg_t;

    typedef struct {
        logic signed [RES_W-1:0] value;
        status_t                 status;
    } peak_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [TIME_W-1:0]        s_sample_time;
    logic signed [DATA_W-1:0] s_sample_value;
    logic                     s_final_sample;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [RES_W-1:0]  m_result_value;
    logic [1:0]               m_status;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_wr_data;

    // Mirror of the register file and of the tracker state.
    tracker_cfg_t             cfg_now;
    logic signed [DATA_W-1:0] peak_value;
    logic [TIME_W-1:0]        peak_time;
    bit                       window_hit;
    bit                       have_peak;
    logic signed [DATA_W-1:0] last_value;
    logic [TIME_W-1:0]        last_time;

    peak_result_t             pending_results[$];
    int unsigned              items_sent    = 0;
    int unsigned              mismatches    = 0;
    bit                       steady_flow   = 1'b0;
    int unsigned              hold_cycles   = 0;
    int unsigned              quiet_cycles  = 0;

    windowed_peak_or_slope_tracker uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_time  (s_sample_time),
        .s_sample_value (s_sample_value),
        .s_final_sample (s_final_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Peak tracker prediction
    // ------------------------------------------------------------------
    function automatic void clear_tracker();
        peak_value = 32'sh8000_0000;
        peak_time  = '0;
        window_hit = 1'b0;
        have_peak  = 1'b0;
        last_value = '0;
        last_time  = '0;
    endfunction

    // First candidate always wins; ties only replace when keep_last is set.
    function automatic void offer_candidate(input logic signed [DATA_W-1:0] val,
                                            input logic [TIME_W-1:0] t);
        if (!have_peak || val > peak_value || (cfg_now.keep_last && val == peak_value)) begin
            peak_value = val;
            peak_time  = t;
            have_peak  = 1'b1;
        end
    endfunction

    function automatic void track_sample(input logic [TIME_W-1:0] t,
                                         input logic signed [DATA_W-1:0] v,
                                         input logic fin);
        longint       dt;
        longint       num;
        longint       q;
        peak_result_t res;
        if (t >= cfg_now.win_lo && t <= cfg_now.win_hi) begin
            if (cfg_now.use_slope) begin
                if (window_hit) begin
                    // signed 33-bit time step; a step back gives a negative divisor
                    dt = longint'({32'd0, t}) - longint'({32'd0, last_time});
                    if (dt != 0) begin
                        num = (longint'(v) - longint'(last_value)) * 65536;
                        q   = num / dt;
                        if (q > longint'(32'sh7FFF_FFFF))
                            q = longint'(32'sh7FFF_FFFF);
                        if (q < longint'(32'sh8000_0000))
                            q = longint'(32'sh8000_0000);
                        offer_candidate(q[31:0], t);
                    end
                end
                last_value = v;
                last_time  = t;
            end else begin
                offer_candidate(v, t);
            end
            window_hit = 1'b1;
        end
        if (fin) begin
            res.value = '0;
            if (!window_hit) begin
                res.status = STATUS_EMPTY;
            end else if (!have_peak) begin
                res.status = STATUS_UNUSABLE;
            end else begin
                res.status = STATUS_FOUND;
                if (cfg_now.report_time)
                    res.value = {1'b0, peak_time};
                else
                    res.value = {peak_value[DATA_W-1], peak_value};
            end
            pending_results.push_back(res);
            clear_tracker();
        end
    endfunction

    // ------------------------------------------------------------------
    // Request monitor and result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        peak_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                track_sample(s_sample_time, s_sample_value, s_final_sample);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: result_value %0d, status %0d",
                           m_result_value, m_status);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_result_value !== want.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               want.value, m_result_value);
                        mismatches++;
                    end
                    if (m_status !== 2'(want.status)) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side back-pressure: stall bursts of random length, none in steady flow.
    always @(posedge aclk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= (hold_cycles == 1);
        end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            hold_cycles <= $urandom_range(1, 9);
            m_ready     <= 1'b0;
        end else begin
            m_ready     <= 1'b1;
        end
    end

    // Hang detector: any handshake or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [TIME_W-1:0] t,
                               input logic [DATA_W-1:0] v,
                               input logic fin);
        if (!steady_flow && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_time  <= t;
        s_sample_value <= v;
        s_final_sample <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop the request line and let everything in flight come out.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Writes every register, then junk to an unused index which must be dropped.
    task automatic apply_config(input tracker_cfg_t c);
        wait_quiet();
        put_reg(REG_WINDOW_START, c.win_lo);
        put_reg(REG_WINDOW_END, c.win_hi);
        put_reg(REG_KEEP_LAST_TIE, {31'($urandom), c.keep_last});
        put_reg(REG_REPORT_TIME, {31'($urandom), c.report_time});
        put_reg(REG_USE_SLOPE, {31'($urandom), c.use_slope});
        put_reg(CFG_IDX_W'($urandom_range(int'(REG_USE_SLOPE) + 1, CFG_IDX_MAX)), $urandom);
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // One waveform: mostly rising time stamps, some repeats, rare jumps and steps back.
    task automatic send_waveform(input logic [TIME_W-1:0] t0, input int len);
        logic [TIME_W-1:0]        t;
        logic signed [DATA_W-1:0] v;
        int                       flavor;
        t      = t0;
        v      = $urandom;
        flavor = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            if (i != 0) begin
                case ($urandom_range(0, 31))
                    0, 1, 2, 3: ;
                    30:      t = t + $urandom;
                    31:      t = t - $urandom_range(1, 50);
                    default: t = t + $urandom_range(1, 300);
                endcase
            end
            case (flavor)
                0: v = $urandom;
                1: v = (int'($urandom_range(0, 6)) - 3) * 65536;   // many equal maxima
                2: v = v + int'($urandom_range(0, 1 << 20)) - (1 << 19);
                default: begin
                    case ($urandom_range(0, 4))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7FFF_FFFF;
                        2:       v = '0;
                        3:       v = '1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            send_sample(t, v, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: value mode, peak value reported, first tie kept.
    task automatic test_value_extremes();
        send_sample(32'd0, 32'h8000_0000, 1'b1);     // lone minimum still becomes the peak
        send_sample(32'd5, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'd6, 32'h0000_0000, 1'b0);
        send_sample(32'd7, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_tie_policy();
        tracker_cfg_t c;
        c = '{win_lo: '0, win_hi: '1, keep_last: 1'b0, report_time: 1'b1, use_slope: 1'b0};
        for (int k = 0; k < 2; k++) begin
            c.keep_last = (k == 1);
            apply_config(c);
            send_sample(32'd10, 32'h0003_0000, 1'b0);
            send_sample(32'd20, 32'h0003_0000, 1'b0);
            send_sample(32'd30, 32'h0000_0001, 1'b1);
        end
    endtask

    task automatic test_window_edges();
        tracker_cfg_t c;
        c = '{win_lo: 32'd100, win_hi: 32'd200, keep_last: 1'b0, report_time: 1'b1,
              use_slope: 1'b0};
        apply_config(c);
        send_sample(32'd99, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'd100, 32'h0000_0001, 1'b0);
        send_sample(32'd200, 32'h0000_0002, 1'b0);
        send_sample(32'd201, 32'h7FFF_FFFF, 1'b1);   // final outside window still reports
        send_sample(32'd50, 32'h0000_0000, 1'b1);    // nothing in window
        c.win_lo = 32'd200;
        c.win_hi = 32'd100;                           // inverted window
        apply_config(c);
        send_sample(32'd150, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_slope_specials();
        tracker_cfg_t c;
        c = '{win_lo: '0, win_hi: '1, keep_last: 1'b0, report_time: 1'b0, use_slope: 1'b1};
        apply_config(c);
        send_sample(32'd1000, 32'h0000_0000, 1'b1);  // single sample: no quotient
        send_sample(32'd10, 32'h0000_0005, 1'b0);
        send_sample(32'd10, 32'h0000_0009, 1'b1);    // zero time step only
        send_sample(32'd100, 32'h0000_0000, 1'b0);
        send_sample(32'd101, 32'h4000_0000, 1'b0);   // saturates high
        send_sample(32'd102, 32'h8000_0000, 1'b1);   // saturates low
        send_sample(32'd50, 32'h0000_0000, 1'b0);
        send_sample(32'd40, 32'hFFFF_0000, 1'b1);    // step back in time
    endtask

    task automatic test_random_waveforms(input int unsigned item_goal);
        tracker_cfg_t      c;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] origin;
        int unsigned       spread;
        int unsigned       stop_at;
        int                phase;
        phase  = 0;
        origin = '0;
        while (items_sent < item_goal) begin
            lo            = $urandom;
            span          = $urandom_range(50, 3000);
            c.keep_last   = $urandom_range(0, 1);
            c.report_time = $urandom_range(0, 1);
            c.use_slope   = (phase % 2 == 0);
            case (phase % 7)
                0: begin
                    c.win_lo = '0;
                    c.win_hi = '1;
                    spread   = 0;
                end
                3: begin
                    c.win_lo = '0;
                    c.win_hi = '0;
                    origin   = 32'hFFFF_FFFE;
                    spread   = 3;
                end
                4: begin
                    c.win_lo = '1;
                    c.win_hi = '1;
                    origin   = 32'hFFFF_FFF0;
                    spread   = 16;
                end
                5: begin
                    c.win_lo = lo + span;
                    c.win_hi = lo;
                    origin   = lo;
                    spread   = span;
                end
                6: begin
                    span     = $urandom_range(0, 20);
                    c.win_lo = lo;
                    c.win_hi = lo + span;
                    origin   = lo - 40;
                    spread   = span + 40;
                end
                default: begin
                    c.win_lo = lo;
                    c.win_hi = lo + span;
                    origin   = lo - 300;
                    spread   = span + 300;
                end
            endcase
            apply_config(c);
            stop_at = items_sent + 90;
            while (items_sent < stop_at && items_sent < item_goal) begin
                if (spread == 0)
                    send_waveform($urandom, $urandom_range(1, 12));
                else
                    send_waveform(origin + $urandom_range(0, spread), $urandom_range(1, 12));
            end
            phase++;
        end
    endtask

    // Closing stretch with both sides always ready.
    task automatic test_back_to_back(input int unsigned item_goal);
        steady_flow = 1'b1;
        test_random_waveforms(item_goal);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample_time  = '0;
        s_sample_value = '0;
        s_final_sample = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        cfg_now        = '{win_lo: '0, win_hi: '1, keep_last: 1'b0, report_time: 1'b0,
                           use_slope: 1'b0};
        clear_tracker();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_value_extremes();
        test_tie_policy();
        test_window_edges();
        test_slope_specials();
        test_random_waveforms(950);
        test_back_to_back(1100);
        wait_quiet();

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- windowed_peak_or_slope_tracker.f -----
rtl/core/wpst_pkg.sv
rtl/core/wpst_div.sv
rtl/core/wpst_dp.sv
rtl/core/wpst_ctrl.sv
rtl/core/windowed_peak_or_slope_tracker.sv
rtl/core/wpst_checker.sv
tb/sv/tb_top.sv
